// File: design/zzr_pkg.sv
// Shared types and constants for the zigzag row reorder unit.
package zzr_pkg;

   localparam int MAX_LEN = 64;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = ADDR_W + 1;
   localparam int ROWS_W  = 7;
   localparam int BYTE_W  = 8;

   typedef struct packed {
      logic              bank;
      logic [CNT_W-1:0]  len;
      logic [CNT_W-1:0]  rows;
      logic              ovf;
   } job_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } rel_type;

endpackage

// File: design/zzr_store.sv
// Two-bank message buffer with one write port and a registered read port.
module zzr_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [zzr_pkg::ADDR_W:0]     wr_addr,
   input  logic [zzr_pkg::BYTE_W-1:0]   wr_data,
   input  logic [zzr_pkg::ADDR_W:0]     rd_addr,
   output logic [zzr_pkg::BYTE_W-1:0]   rd_data
);

   logic [zzr_pkg::BYTE_W-1:0] mem [0:2*zzr_pkg::MAX_LEN-1];
   logic [zzr_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/zzr_front.sv
// Front end: takes message bytes, fills the free bank and queues a job on the last byte.
module zzr_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [zzr_pkg::BYTE_W-1:0]    req_tdata,
   input  logic                          req_tlast,
   input  logic                          csr_wen,
   input  logic [zzr_pkg::ROWS_W-1:0]    csr_wdata,
   input  zzr_pkg::rel_type              rel,
   input  logic                          job_full,
   output logic                          job_push,
   output zzr_pkg::job_type              job,
   output logic                          wr_en,
   output logic [zzr_pkg::ADDR_W:0]      wr_addr,
   output logic [zzr_pkg::BYTE_W-1:0]    wr_data
);

   logic [zzr_pkg::ROWS_W-1:0] rows_ff;
   logic [zzr_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       drop_ff, drop_in;
   logic                       bank_ff, bank_in;
   logic [1:0]                 busy_ff, busy_in;
   logic                       acc, room;
   logic [zzr_pkg::CNT_W-1:0]  len;
   logic [zzr_pkg::CNT_W-1:0]  rows_eff;

   assign req_tready = !busy_ff[bank_ff] && !job_full;
   assign acc        = req_tvalid && req_tready;
   assign room       = (cnt_ff < zzr_pkg::CNT_W'(zzr_pkg::MAX_LEN));
   assign len        = room ? cnt_ff + 1'b1 : cnt_ff;

   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = zzr_pkg::CNT_W'(1);
      end else if (zzr_pkg::CNT_W'(rows_ff) > len) begin
         rows_eff = len;
      end else begin
         rows_eff = zzr_pkg::CNT_W'(rows_ff);
      end
   end

   assign wr_en    = acc && room;
   assign wr_addr  = {bank_ff, cnt_ff[zzr_pkg::ADDR_W-1:0]};
   assign wr_data  = req_tdata;
   assign job_push = acc && req_tlast;
   assign job.bank = bank_ff;
   assign job.len  = len;
   assign job.rows = rows_eff;
   assign job.ovf  = drop_ff || !room;

   always_comb begin
      cnt_in  = cnt_ff;
      drop_in = drop_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (acc) begin
         if (room) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
         if (req_tlast) begin
            cnt_in           = '0;
            drop_in          = 1'b0;
            bank_in          = !bank_ff;
            busy_in[bank_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= zzr_pkg::ROWS_W'(1);
         cnt_ff  <= '0;
         drop_ff <= 1'b0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         if (csr_wen) begin
            rows_ff <= csr_wdata;
         end
         cnt_ff  <= cnt_in;
         drop_ff <= drop_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

// File: design/zzr_fifo.sv
// Two-entry job queue between front and back end.
module zzr_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  zzr_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output zzr_pkg::job_type head
);

   zzr_pkg::job_type slot_ff [0:1];
   logic             wptr_ff, rptr_ff;
   logic [1:0]       count_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push && !full) begin
            wptr_ff <= !wptr_ff;
         end
         if (pop && !empty) begin
            rptr_ff <= !rptr_ff;
         end
         count_ff <= count_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
   end

endmodule

// File: design/zzr_back.sv
// Back end: walks a stored message in zigzag order and drives the response register.
module zzr_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_empty,
   input  zzr_pkg::job_type             job,
   output logic                         job_pop,
   output logic [zzr_pkg::ADDR_W:0]     rd_addr,
   input  logic [zzr_pkg::BYTE_W-1:0]   rd_data,
   output zzr_pkg::rel_type             rel,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [zzr_pkg::BYTE_W-1:0]   rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tuser
);

   typedef enum logic [1:0] {IDLE, FETCH, HOLD} state_type;

   state_type                   state_ff;
   logic                        bank_ff;
   logic [zzr_pkg::CNT_W-1:0]   len_ff;
   logic [zzr_pkg::CNT_W-1:0]   rows_ff;
   logic                        ovf_ff;
   logic [zzr_pkg::ADDR_W-1:0]  row_ff;
   logic [zzr_pkg::ADDR_W-1:0]  idx_ff;
   logic [zzr_pkg::ADDR_W-1:0]  k_ff;
   logic                        first_ff;
   logic                        last_ff;
   logic                        ovalid_ff;
   logic [zzr_pkg::BYTE_W-1:0]  odata_ff;
   logic                        olast_ff;
   logic                        ouser_ff;

   logic                        out_free;
   logic [zzr_pkg::CNT_W-1:0]   row_w;
   logic [zzr_pkg::CNT_W:0]     stride;
   logic [zzr_pkg::CNT_W:0]     sum;
   logic                        edge_row;

   assign out_free = !ovalid_ff || rsp_tready;
   assign row_w    = zzr_pkg::CNT_W'(row_ff);
   assign edge_row = (row_ff == '0) || (row_w == rows_ff - 1'b1);

   always_comb begin
      if (rows_ff == zzr_pkg::CNT_W'(1)) begin
         stride = (zzr_pkg::CNT_W+1)'(1);
      end else if (edge_row) begin
         stride = {rows_ff - 1'b1, 1'b0};
      end else if (first_ff) begin
         stride = {rows_ff - row_w - 1'b1, 1'b0};
      end else begin
         stride = {row_w, 1'b0};
      end
   end

   // index held until the byte is loaded, so the read data stays put while stalled
   assign sum     = (zzr_pkg::CNT_W+1)'(idx_ff) + stride;
   assign rd_addr = {bank_ff, idx_ff};
   assign job_pop = (state_ff == IDLE) && !job_empty;

   assign rel.valid = (state_ff == HOLD) && out_free && last_ff;
   assign rel.bank  = bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         if ((state_ff == HOLD) && out_free) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (!job_empty) begin
                  bank_ff  <= job.bank;
                  len_ff   <= job.len;
                  rows_ff  <= job.rows;
                  ovf_ff   <= job.ovf;
                  row_ff   <= '0;
                  idx_ff   <= '0;
                  k_ff     <= '0;
                  first_ff <= 1'b1;
                  state_ff <= FETCH;
               end
            end
            FETCH: begin
               last_ff  <= (zzr_pkg::CNT_W'(k_ff) == len_ff - 1'b1);
               state_ff <= HOLD;
            end
            HOLD: begin
               if (out_free) begin
                  odata_ff <= rd_data;
                  olast_ff <= last_ff;
                  ouser_ff <= ovf_ff;
                  k_ff     <= k_ff + 1'b1;
                  if (sum < (zzr_pkg::CNT_W+1)'(len_ff)) begin
                     idx_ff   <= sum[zzr_pkg::ADDR_W-1:0];
                     first_ff <= !first_ff;
                  end else begin
                     row_ff   <= row_ff + 1'b1;
                     idx_ff   <= row_ff + 1'b1;
                     first_ff <= 1'b1;
                  end
                  state_ff <= last_ff ? IDLE : FETCH;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ouser_ff;

endmodule

// File: design/zigzag_row_reorder_unit.sv
// Top level of the zigzag row reorder unit: front end, job queue, buffer and back end.
//
//   channel  dir  tdata (low bit up)   tlast     tuser
//   req      in   in_byte [7:0]        in_last   -
//   rsp      out  out_byte [7:0]       out_last  overflow
//   csr      in   num_rows [6:0] on csr_wdata, written when csr_wen is high
//
// A request byte is written into the free bank as it is accepted; each response byte
// passes through two back-end steps (buffer read, then response register load), and
// each message first passes an idle step that takes the job. Two buffer banks let the
// next message fill while the previous one drains. Reset is synchronous and clears
// control state only. req_tready drops when both banks hold messages.
module zigzag_row_reorder_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [zzr_pkg::BYTE_W-1:0]   req_tdata,   // in_byte
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [zzr_pkg::BYTE_W-1:0]   rsp_tdata,   // out_byte
   output logic                         rsp_tlast,
   output logic                         rsp_tuser,   // overflow
   input  logic                         csr_wen,
   input  logic [zzr_pkg::ROWS_W-1:0]   csr_wdata
);

   zzr_pkg::rel_type            rel;
   zzr_pkg::job_type            push_job, head_job;
   logic                        job_push, job_pop, job_full, job_empty;
   logic                        wr_en;
   logic [zzr_pkg::ADDR_W:0]    wr_addr, rd_addr;
   logic [zzr_pkg::BYTE_W-1:0]  wr_data, rd_data;

   zzr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rel        (rel),
      .job_full   (job_full),
      .job_push   (job_push),
      .job        (push_job),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   zzr_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (job_full),
      .pop      (job_pop),
      .empty    (job_empty),
      .head     (head_job)
   );

   zzr_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   zzr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (job_empty),
      .job        (head_job),
      .job_pop    (job_pop),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rel        (rel),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: design/zzr_checker.sv
// Port-level checks for the zigzag row reorder unit, bound to the top level.
module zzr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [zzr_pkg::BYTE_W-1:0]   rsp_tdata,
   input logic                         rsp_tlast,
   input logic                         rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("not ready for requests after reset");

endmodule

bind zigzag_row_reorder_unit zzr_checker u_zzr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// File: verif/zigzag_row_reorder_unit_test.sv
// Testbench for zigzag_row_reorder_unit: stream stimulus against a rail fence predictor.
`timescale 1ns / 1ps

module zigzag_row_reorder_unit_test;

   typedef struct packed {
      logic [zzr_pkg::BYTE_W-1:0] data;
      logic                       last;
      logic                       ovf;
   } fence_beat_type;

   typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} ready_mode_type;

   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_LIMIT   = 20000;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [zzr_pkg::BYTE_W-1:0]  req_tdata  = '0;   // in_byte
   logic                        req_tlast  = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [zzr_pkg::BYTE_W-1:0]  rsp_tdata;         // out_byte
   logic                        rsp_tlast;
   logic                        rsp_tuser;         // overflow
   logic                        csr_wen    = 1'b0;
   logic [zzr_pkg::ROWS_W-1:0]  csr_wdata  = '0;

   // predictor state
   logic [zzr_pkg::BYTE_W-1:0]  msg_buf[$];
   logic                        msg_dropped = 1'b0;
   logic [zzr_pkg::ROWS_W-1:0]  rows_shadow = zzr_pkg::ROWS_W'(1);
   fence_beat_type              fence_beats_due[$];

   int                 fail_count    = 0;
   int                 items_sent    = 0;
   int                 msgs_done     = 0;
   int                 ovf_msgs      = 0;
   int                 beats_checked = 0;
   int                 rows_written  = 0;
   int                 input_stalls  = 0;
   int                 burst_left    = 0;
   bit                 gaps_on       = 1'b0;
   int                 hold_order    = 0;
   ready_mode_type     ready_mode    = RDY_ALWAYS;

   zigzag_row_reorder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // rail fence order of the buffered message, appended to the due list
   function automatic void encode_message();
      fence_beat_type beat;
      int             n, rows, idx, stride_a, stride_b, k;
      bit             use_b;
      n        = msg_buf.size();
      rows     = int'(rows_shadow);
      k        = 0;
      beat.ovf = msg_dropped;
      if (rows <= 1) begin
         for (int i = 0; i < n; i++) begin
            beat.data = msg_buf[i];
            beat.last = (i == n - 1);
            fence_beats_due.push_back(beat);
         end
      end else begin
         for (int r = 0; r < rows && r < n; r++) begin
            if (r == 0 || r == rows - 1) begin
               stride_a = 2 * (rows - 1);
               stride_b = stride_a;
            end else begin
               stride_a = 2 * (rows - r - 1);
               stride_b = 2 * r;
            end
            idx   = r;
            use_b = 1'b0;
            while (idx < n) begin
               beat.data = msg_buf[idx];
               beat.last = (k == n - 1);
               fence_beats_due.push_back(beat);
               k++;
               idx  += use_b ? stride_b : stride_a;
               use_b = !use_b;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      fence_beat_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (fence_beats_due.size() == 0) begin
               $error("unexpected response: out_byte %0h out_last %0b overflow %0b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               fail_count++;
            end else begin
               want = fence_beats_due.pop_front();
               beats_checked++;
               if (rsp_tdata !== want.data) begin
                  $error("out_byte: expected %0h, got %0h", want.data, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("out_last: expected %0b, got %0b", want.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== want.ovf) begin
                  $error("overflow: expected %0b, got %0b", want.ovf, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && !req_tready)
            input_stalls++;
         if (req_tvalid && req_tready) begin
            if (msg_buf.size() < zzr_pkg::MAX_LEN)
               msg_buf.push_back(req_tdata);
            else
               msg_dropped = 1'b1;
            if (req_tlast) begin
               encode_message();
               msgs_done++;
               if (msg_dropped)
                  ovf_msgs++;
               msg_buf.delete();
               msg_dropped = 1'b0;
            end
         end
         if (csr_wen)
            rows_shadow = csr_wdata;
      end
   end

   // response side: own stall pattern, plus long hold-offs on demand
   initial begin : rsp_side
      int hold_left;
      int phase;
      hold_left = 0;
      phase     = 0;
      forever begin
         @(posedge clock);
         if (hold_order > 0) begin
            hold_left  = hold_order;
            hold_order = 0;
         end
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_mode)
               RDY_ALWAYS:  rsp_tready <= 1'b1;
               RDY_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
               default:     rsp_tready <= ((phase % 7) < 4);
            endcase
         end
      end
   end

   task automatic send_item(input logic [zzr_pkg::BYTE_W-1:0] data, input logic last);
      int gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_item(zzr_pkg::BYTE_W'($urandom_range(0, 255)), i == len - 1);
   endtask

   task automatic pause_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (fence_beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rows(input logic [zzr_pkg::ROWS_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      rows_written++;
   endtask

   // one row from reset: bytes pass straight through
   task automatic test_reset_rows();
      gaps_on    = 1'b0;
      ready_mode = RDY_ALWAYS;
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h55, 1'b0);
      send_item(8'hAA, 1'b1);
      send_item(8'h80, 1'b1);
      pause_for_drain();
   endtask

   // zero rows, two, three, and rows at or above message length
   task automatic test_row_extremes();
      int row_set[5];
      int len_set[5];
      row_set = '{0, 2, 3, 64, 127};
      len_set = '{2, 5, 7, 2, 4};
      ready_mode = RDY_PATTERN;
      for (int i = 0; i < 5; i++) begin
         write_rows(zzr_pkg::ROWS_W'(row_set[i]));
         send_message(len_set[i]);
         pause_for_drain();
      end
   endtask

   // exactly full, then two bytes dropped including the final one
   task automatic test_buffer_limit();
      write_rows(zzr_pkg::ROWS_W'($urandom_range(2, 6)));
      gaps_on    = 1'b1;
      ready_mode = RDY_RANDOM;
      send_message(zzr_pkg::MAX_LEN);
      send_message(zzr_pkg::MAX_LEN + 2);
      pause_for_drain();
   endtask

   // output held off long enough for both banks to fill and the input to stall
   task automatic test_output_hold();
      write_rows(zzr_pkg::ROWS_W'(3));
      gaps_on    = 1'b0;
      ready_mode = RDY_ALWAYS;
      hold_order = HOLD_CYCLES;
      for (int i = 0; i < 3; i++)
         send_message(4);
      pause_for_drain();
   endtask

   task automatic test_random_traffic(input int count);
      int target;
      int len;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 3) == 0) begin
            pause_for_drain();
            case ($urandom_range(0, 5))
               0:       write_rows(zzr_pkg::ROWS_W'(0));
               1:       write_rows(zzr_pkg::ROWS_W'(1));
               2:       write_rows(zzr_pkg::ROWS_W'(127));
               3:       write_rows(zzr_pkg::ROWS_W'(64));
               default: write_rows(zzr_pkg::ROWS_W'($urandom_range(2, 9)));
            endcase
         end
         gaps_on    = ($urandom_range(0, 3) != 0);
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         len        = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24)
                                                  : $urandom_range(1, 12);
         send_message(len);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_rows();
      test_row_extremes();
      test_buffer_limit();
      test_output_hold();
      test_random_traffic(12);

      req_tvalid <= 1'b0;
      @(posedge clock);
      for (int c = 0; c < DRAIN_LIMIT && fence_beats_due.size() != 0; c++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fence_beats_due.size() != 0) begin
         $error("%0d expected responses never arrived", fence_beats_due.size());
         fail_count++;
      end

      $display("run covered %0d requests in %0d messages (%0d with dropped bytes), %0d rows writes",
               items_sent, msgs_done, ovf_msgs, rows_written);
      $display("%0d response bytes checked, input stalled for %0d cycles",
               beats_checked, input_stalls);
      if (fail_count == 0)
         $display("zigzag_row_reorder_unit verification clean");
      else
         $display("zigzag_row_reorder_unit verification failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("zigzag_row_reorder_unit verification failed");
      $finish;
   end

endmodule

// File: files.f
design/zzr_pkg.sv
design/zzr_store.sv
design/zzr_front.sv
design/zzr_fifo.sv
design/zzr_back.sv
design/zigzag_row_reorder_unit.sv
design/zzr_checker.sv
verif/zigzag_row_reorder_unit_test.sv
